/* src/bal_pkg.sv */
`default_nettype none

package bal_pkg;

  // Default list capacity
  localparam int CAPACITY_DEF = 8;

  // Field widths fixed by the interface
  localparam int OP_W   = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int ROT_W  = 8;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 3;
  localparam int LCNT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_BACK  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_DISPLAY   = 4'd7,
    OP_ROTATE    = 4'd8
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef logic [FIDX_W-1:0] fidx_t;
  typedef logic [LCNT_W-1:0] lcnt_t;

  // One result item as it leaves the core
  typedef struct packed {
    status_t                  status;
    fidx_t                    found_index;
    logic signed [VAL_W-1:0]  out_value;
    lcnt_t                    list_count;
    logic                     last;
  } res_t;

  // Kind of bank-to-bank copy pass
  typedef enum logic [1:0] {
    K_INS,
    K_DEL,
    K_ROT
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_COPY,
    S_SRCH,
    S_DISP_RD,
    S_DISP_EMIT,
    S_DONE
  } core_state_t;

endpackage

`default_nettype wire

/* src/bal_mod.sv */
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle
module bal_mod #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bal_pkg::ROT_W-1:0]   dividend,
  input  wire logic [$clog2(CAPACITY+1)-1:0] divisor,
  output logic                             done,
  output logic [$clog2(CAPACITY+1)-1:0]    rem
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(bal_pkg::ROT_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(bal_pkg::ROT_W - 1);

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [bal_pkg::ROT_W-1:0] q;
  logic [CW-1:0]             r;
  logic [CW-1:0]             dvs;
  logic [CW:0]               trial;
  logic [CW-1:0]             r_next;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {r, q[bal_pkg::ROT_W-1]};
    if (trial >= {1'b0, dvs}) begin
      r_next = CW'(trial - {1'b0, dvs});
    end else begin
      r_next = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == LAST_STEP)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      q    <= dividend;
      r    <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      q    <= {q[bal_pkg::ROT_W-2:0], 1'b0};
      r    <= r_next;
    end
  end

  assign rem = r;

endmodule

`default_nettype wire

/* src/bal_core.sv */
`default_nettype none

// Sequencer, two-bank element store and shared index adder
module bal_core #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bal_pkg::OP_W-1:0]          op,
  input  wire logic signed [bal_pkg::VAL_W-1:0]  item_value,
  input  wire logic [bal_pkg::POS_W-1:0]         position,
  input  wire logic [bal_pkg::ROT_W-1:0]         rotate_amount,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output bal_pkg::res_t                          res
);

  localparam int IW        = $clog2(CAPACITY);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int AW        = IW + 1;
  localparam int MEM_DEPTH = 2 ** AW;
  localparam int CMP_W     = bal_pkg::POS_W + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  bal_pkg::core_state_t state, state_next;
  bal_pkg::kind_t       kind, kind_next;
  bal_pkg::status_t     st, st_next;

  logic                        act, act_next;
  logic [CW-1:0]               count, count_next;
  logic [CW-1:0]               j, j_next;
  logic [CW-1:0]               len, len_next;
  logic [CW-1:0]               idx, idx_next;
  logic [CW-1:0]               off, off_next;
  logic [IW-1:0]               fidx, fidx_next;
  logic signed [bal_pkg::VAL_W-1:0] value, value_next;

  logic                        p_valid, p_valid_next;
  logic [IW-1:0]               p_dst, p_dst_next;
  logic                        p_useval, p_useval_next;
  logic                        chk_valid, chk_valid_next;
  logic [IW-1:0]               chk_idx, chk_idx_next;

  logic [bal_pkg::VAL_W-1:0]   mem [MEM_DEPTH];
  logic [bal_pkg::VAL_W-1:0]   rdata;
  logic [AW-1:0]               rd_addr;

  logic                        mod_start;
  logic                        mod_done;
  logic [CW-1:0]               mod_rem;

  logic [CW:0]                 addend;
  logic [CW:0]                 sum;
  logic [CW:0]                 src;
  logic [CMP_W-1:0]            pos_x;
  logic [CMP_W-1:0]            cnt_x;
  logic [CW-1:0]               j_p1;
  logic                        disp_last;

  bal_mod #(
    .CAPACITY (CAPACITY)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (rotate_amount),
    .divisor  (count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Shared adder: source index of the copy pass for destination j
  always_comb begin
    addend = '0;
    case (kind)
      bal_pkg::K_INS: begin
        if (j > idx) begin
          addend = '1;
        end
      end
      bal_pkg::K_DEL: begin
        if (j >= idx) begin
          addend = (CW+1)'(1);
        end
      end
      bal_pkg::K_ROT: begin
        addend = {1'b0, off};
      end
      default: begin
        addend = '0;
      end
    endcase
    sum = {1'b0, j} + addend;
    if ((kind == bal_pkg::K_ROT) && (sum >= {1'b0, count})) begin
      src = sum - {1'b0, count};
    end else begin
      src = sum;
    end
  end

  assign pos_x     = CMP_W'(position);
  assign cnt_x     = CMP_W'(count);
  assign j_p1      = j + CW'(1);
  assign disp_last = (j_p1 == count);

  // Sequencer: next state, counters and result
  always_comb begin
    state_next     = state;
    kind_next      = kind;
    st_next        = st;
    act_next       = act;
    count_next     = count;
    j_next         = j;
    len_next       = len;
    idx_next       = idx;
    off_next       = off;
    fidx_next      = fidx;
    value_next     = value;
    p_valid_next   = 1'b0;
    p_dst_next     = p_dst;
    p_useval_next  = 1'b0;
    chk_valid_next = chk_valid;
    chk_idx_next   = chk_idx;
    rd_addr        = {act, j[IW-1:0]};
    mod_start      = 1'b0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    res.status      = st;
    res.found_index = bal_pkg::fidx_t'(fidx);
    res.out_value   = '0;
    res.list_count  = bal_pkg::lcnt_t'(count);
    res.last        = 1'b1;

    case (state)
      bal_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_next     = item_value;
          chk_valid_next = 1'b0;
          j_next         = '0;
          fidx_next      = '0;
          st_next        = bal_pkg::ST_OK;
          state_next     = bal_pkg::S_DONE;
          case (bal_pkg::op_t'(op))
            bal_pkg::OP_INS_FRONT, bal_pkg::OP_INS_BACK, bal_pkg::OP_INS_AT: begin
              if (count >= CAP_C) begin
                st_next = bal_pkg::ST_FULL;
              end else if ((bal_pkg::op_t'(op) == bal_pkg::OP_INS_AT) &&
                           ((position == '0) || (pos_x > cnt_x + CMP_W'(1)))) begin
                st_next = bal_pkg::ST_BADPOS;
              end else begin
                kind_next  = bal_pkg::K_INS;
                len_next   = count + CW'(1);
                state_next = bal_pkg::S_COPY;
                if (bal_pkg::op_t'(op) == bal_pkg::OP_INS_FRONT) begin
                  idx_next = '0;
                end else if (bal_pkg::op_t'(op) == bal_pkg::OP_INS_BACK) begin
                  idx_next = count;
                end else begin
                  idx_next = CW'(position - bal_pkg::POS_W'(1));
                end
              end
            end
            bal_pkg::OP_DEL_FRONT, bal_pkg::OP_DEL_BACK, bal_pkg::OP_DEL_AT: begin
              if (count == '0) begin
                st_next = bal_pkg::ST_EMPTY;
              end else if ((bal_pkg::op_t'(op) == bal_pkg::OP_DEL_AT) &&
                           ((position == '0) || (pos_x > cnt_x))) begin
                st_next = bal_pkg::ST_BADPOS;
              end else begin
                kind_next  = bal_pkg::K_DEL;
                len_next   = count - CW'(1);
                state_next = bal_pkg::S_COPY;
                if (bal_pkg::op_t'(op) == bal_pkg::OP_DEL_FRONT) begin
                  idx_next = '0;
                end else if (bal_pkg::op_t'(op) == bal_pkg::OP_DEL_BACK) begin
                  idx_next = count - CW'(1);
                end else begin
                  idx_next = CW'(position - bal_pkg::POS_W'(1));
                end
              end
            end
            bal_pkg::OP_SEARCH: begin
              state_next = bal_pkg::S_SRCH;
            end
            bal_pkg::OP_DISPLAY: begin
              if (count == '0) begin
                st_next = bal_pkg::ST_EMPTY;
              end else begin
                state_next = bal_pkg::S_DISP_RD;
              end
            end
            bal_pkg::OP_ROTATE: begin
              if (count == '0) begin
                st_next = bal_pkg::ST_EMPTY;
              end else begin
                mod_start  = 1'b1;
                state_next = bal_pkg::S_MOD;
              end
            end
            default: begin
              st_next = bal_pkg::ST_OK;
            end
          endcase
        end
      end

      // Wait for the rotate amount reduced modulo count
      bal_pkg::S_MOD: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            state_next = bal_pkg::S_DONE;
          end else begin
            kind_next  = bal_pkg::K_ROT;
            off_next   = count - mod_rem;
            len_next   = count;
            state_next = bal_pkg::S_COPY;
          end
        end
      end

      // Copy the active bank into the other one, one element per cycle
      bal_pkg::S_COPY: begin
        if (j < len) begin
          rd_addr       = {act, src[IW-1:0]};
          p_valid_next  = 1'b1;
          p_dst_next    = j[IW-1:0];
          p_useval_next = (kind == bal_pkg::K_INS) && (j == idx);
          j_next        = j_p1;
        end else begin
          act_next   = ~act;
          state_next = bal_pkg::S_DONE;
          if (kind == bal_pkg::K_INS) begin
            count_next = count + CW'(1);
          end else if (kind == bal_pkg::K_DEL) begin
            count_next = count - CW'(1);
          end
        end
      end

      // Read one element per cycle, compare it in the next cycle
      bal_pkg::S_SRCH: begin
        if (chk_valid && (rdata == value)) begin
          fidx_next      = chk_idx;
          st_next        = bal_pkg::ST_OK;
          chk_valid_next = 1'b0;
          state_next     = bal_pkg::S_DONE;
        end else if (j < count) begin
          chk_valid_next = 1'b1;
          chk_idx_next   = j[IW-1:0];
          j_next         = j_p1;
        end else if (chk_valid) begin
          chk_valid_next = 1'b0;
        end else begin
          st_next    = bal_pkg::ST_NOTFOUND;
          state_next = bal_pkg::S_DONE;
        end
      end

      bal_pkg::S_DISP_RD: begin
        state_next = bal_pkg::S_DISP_EMIT;
      end

      // Hold the element until the output stage takes it
      bal_pkg::S_DISP_EMIT: begin
        res_valid       = 1'b1;
        res.status      = bal_pkg::ST_OK;
        res.found_index = '0;
        res.out_value   = rdata;
        res.last        = disp_last;
        if (res_ready) begin
          j_next     = j_p1;
          state_next = disp_last ? bal_pkg::S_IDLE : bal_pkg::S_DISP_RD;
        end
      end

      bal_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = bal_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bal_pkg::S_IDLE;
      act       <= 1'b0;
      count     <= '0;
      p_valid   <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      act       <= act_next;
      count     <= count_next;
      p_valid   <= p_valid_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    st       <= st_next;
    j        <= j_next;
    len      <= len_next;
    idx      <= idx_next;
    off      <= off_next;
    fidx     <= fidx_next;
    value    <= value_next;
    p_dst    <= p_dst_next;
    p_useval <= p_useval_next;
    chk_idx  <= chk_idx_next;
  end

  // Element store: registered read, write into the inactive bank
  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (p_valid) begin
      mem[{~act, p_dst}] <= p_useval ? value : rdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("list count exceeds capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != bal_pkg::S_IDLE))
    else $error("accepted item did not start");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(act)) |-> $past(state == bal_pkg::S_COPY))
    else $error("bank switched outside a copy pass");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |-> $past(state == bal_pkg::S_COPY))
    else $error("count changed outside a copy pass");

  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == bal_pkg::S_MOD))
    else $error("remainder finished while not waiting for it");

endmodule

`default_nettype wire

/* src/bounded_array_list_engine.sv */
// Bounded array list engine.
// Input channel (in_valid/in_ready) carries op, item_value, position and
// rotate_amount; one transfer is one list operation. The output channel
// (out_valid/out_ready) carries status, found_index, out_value, list_count
// and last. Every operation yields one result with last set, except a
// display of a non-empty list, which yields count results in list order.
// One item at a time: in_ready is high only while the sequencer is idle.
// Per item: inserts and deletes run one copy pass; search reads until a
//   match or the end of the list; display reads and emits each element;
//   rotate runs the 8-step remainder unit, then one copy pass, or goes
//   straight to the result when the amount is a multiple of the count;
//   errors and unused codes go straight to the result. The result reaches
//   the ports through the output register.
// Inserts, deletes and rotates copy the list between two memory banks,
// one element per cycle over the single read and write port.
// Reset empties the list; element storage needs no clearing.
// A stalled receiver holds the output register; the sequencer then waits,
// and the next item is taken as soon as the last result sits in that register.
`default_nettype none

module bounded_array_list_engine #(
  parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bal_pkg::OP_W-1:0]          op,
  input  wire logic signed [bal_pkg::VAL_W-1:0]  item_value,
  input  wire logic [bal_pkg::POS_W-1:0]         position,
  input  wire logic [bal_pkg::ROT_W-1:0]         rotate_amount,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bal_pkg::STAT_W-1:0]             status,
  output logic [bal_pkg::FIDX_W-1:0]             found_index,
  output logic signed [bal_pkg::VAL_W-1:0]       out_value,
  output logic [bal_pkg::LCNT_W-1:0]             list_count,
  output logic                                   last
);

  logic          res_valid;
  logic          res_ready;
  bal_pkg::res_t res;
  bal_pkg::res_t out_q;

  bal_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .item_value    (item_value),
    .position      (position),
    .rotate_amount (rotate_amount),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign status      = out_q.status;
  assign found_index = out_q.found_index;
  assign out_value   = out_q.out_value;
  assign list_count  = out_q.list_count;
  assign last        = out_q.last;

endmodule

`default_nettype wire
